/* src/stun_binding_response_parser_macros.svh */
// ----------------------------------------------------------------------------
// STUN binding response parser assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STUN_BINDING_RESPONSE_PARSER_MACROS_SVH
`define STUN_BINDING_RESPONSE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STUNBRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("stunbrp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STUNBRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("stunbrp assertion failed");

`endif

/* src/stunbrp_pkg.sv */
// ----------------------------------------------------------------------------
// STUN binding response parser package
// Types, codes and constants shared by the parser modules and the checker.
// ----------------------------------------------------------------------------
package stunbrp_pkg;

  localparam int POS_W        = 17;
  localparam int AEND_W       = 18;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 64;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 152;

  localparam logic [POS_W-1:0]  POS_MAX       = 17'd131071;
  localparam logic [POS_W-1:0]  HDR_BYTES     = 17'd20;
  localparam logic [AEND_W-1:0] AEND_RESET    = 18'd24;
  localparam logic [31:0]       MAGIC_COOKIE  = 32'h2112A442;
  localparam logic [47:0]       XOR_MASK      = {MAGIC_COOKIE[31:16], MAGIC_COOKIE};
  localparam logic [7:0]        TOP_BITS_MASK = 8'hC0;
  localparam logic [7:0]        FAMILY_IPV4   = 8'h01;
  localparam logic [15:0]       MIN_ADDR_LEN  = 16'd8;

  localparam logic [15:0] MSG_BINDING_REQ = 16'h0001;
  localparam logic [15:0] MSG_BINDING_OK  = 16'h0101;
  localparam logic [15:0] ATTR_MAPPED     = 16'h0001;
  localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;

  localparam logic [CFG_INDEX_W-1:0] CFG_ID_HIGH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ID_LOW  = 1'd1;

  typedef enum logic [2:0] {
    ST_XOR_ADDR    = 3'd0,
    ST_PLAIN_ADDR  = 3'd1,
    ST_NOT_STUN    = 3'd2,
    ST_NOT_SUCCESS = 3'd3,
    ST_ID_MISMATCH = 3'd4,
    ST_NONE_FOUND  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_OTHER    = 2'd0,
    KIND_BIND_REQ = 2'd1,
    KIND_BIND_OK  = 2'd2
  } kind_t;

  // Packed so that status lands in the lowest bits.
  typedef struct packed {
    logic [63:0] id_low;
    logic [31:0] id_high;
    logic [15:0] mapped_port;
    logic [31:0] mapped_address;
    kind_t       message_kind;
    status_t     status;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  typedef struct packed {
    logic    valid;
    result_t result;
  } res_beat_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = MAGIC_COOKIE[31:24];
      2'd1:    v = MAGIC_COOKIE[23:16];
      2'd2:    v = MAGIC_COOKIE[15:8];
      default: v = MAGIC_COOKIE[7:0];
    endcase
    return v;
  endfunction

  function automatic logic [16:0] pad4(input logic [15:0] len);
    logic [16:0] s;
    s = {1'b0, len} + 17'd3;
    return {s[16:2], 2'b00};
  endfunction

endpackage

/* src/stunbrp_cfg.sv */
// ----------------------------------------------------------------------------
// STUN parser configuration registers
// Holds the expected transaction id written over the configuration channel.
// ----------------------------------------------------------------------------
module stunbrp_cfg import stunbrp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [31:0]            exp_id_high,
  output logic [63:0]            exp_id_low
);

  logic [31:0] exp_id_high_r;
  logic [63:0] exp_id_low_r;

  assign cfg_ready   = 1'b1;
  assign exp_id_high = exp_id_high_r;
  assign exp_id_low  = exp_id_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_high_r <= '0;
      exp_id_low_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ID_HIGH: exp_id_high_r <= cfg_data[31:0];
        CFG_ID_LOW:  exp_id_low_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* src/stunbrp_parser.sv */
// ----------------------------------------------------------------------------
// STUN parser byte engine
// Registers each incoming beat, then updates the header capture and the
// attribute walk in one step, and forms the result on the final byte.
// ----------------------------------------------------------------------------
module stunbrp_parser import stunbrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tlast,
  input  logic [31:0]           exp_id_high,
  input  logic [63:0]           exp_id_low,
  input  logic                  out_free,
  output res_beat_t             res
);

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [15:0]       mtype_r, mtype_nxt;
  logic [15:0]       dlen_r, dlen_nxt;
  logic [1:0]        hflags_r, hflags_nxt;
  logic [31:0]       idu_r, idu_nxt;
  logic [63:0]       idl_r, idl_nxt;
  logic [31:0]       ahdr_r, ahdr_nxt;
  logic [AEND_W-1:0] aend_r, aend_nxt;
  logic [15:0]       voff_r, voff_nxt;
  logic              in_value_r, in_value_nxt;
  logic              stop_r, stop_nxt;
  logic              plain_found_r, plain_found_nxt;
  logic              xor_found_r, xor_found_nxt;
  logic              fam_r, fam_nxt;
  logic [47:0]       pend_r, pend_nxt;
  logic [47:0]       plain_ep_r, plain_ep_nxt;
  logic [47:0]       xor_ep_r, xor_ep_nxt;

  logic              go;
  logic [7:0]        b;
  logic [POS_W-1:0]  limit;
  logic [31:0]       hdr_new;
  logic [15:0]       alen;
  logic [16:0]       vpad;
  logic [16:0]       voff_inc;
  logic              stun;
  result_t           result;

  assign go        = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || go;
  assign b         = s1_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_comb begin
    pos_nxt         = (pos_r == POS_MAX) ? pos_r : pos_r + 17'd1;
    mtype_nxt       = mtype_r;
    dlen_nxt        = dlen_r;
    hflags_nxt      = hflags_r;
    idu_nxt         = idu_r;
    idl_nxt         = idl_r;
    ahdr_nxt        = ahdr_r;
    aend_nxt        = aend_r;
    voff_nxt        = voff_r;
    in_value_nxt    = in_value_r;
    stop_nxt        = stop_r;
    plain_found_nxt = plain_found_r;
    xor_found_nxt   = xor_found_r;
    fam_nxt         = fam_r;
    pend_nxt        = pend_r;
    plain_ep_nxt    = plain_ep_r;
    xor_ep_nxt      = xor_ep_r;
    limit           = {1'b0, dlen_r} + HDR_BYTES;
    hdr_new         = {ahdr_r[23:0], b};
    alen            = hdr_new[15:0];
    vpad            = pad4(ahdr_r[15:0]);
    voff_inc        = {1'b0, voff_r} + 17'd1;

    if (pos_r < 17'd2) begin
      mtype_nxt = {mtype_r[7:0], b};
      if (pos_r == 17'd0 && (b & TOP_BITS_MASK) != 8'd0) begin
        hflags_nxt[0] = 1'b1;
      end
    end else if (pos_r < 17'd4) begin
      dlen_nxt = {dlen_r[7:0], b};
    end else if (pos_r < 17'd8) begin
      if (b != cookie_byte(pos_r[1:0])) begin
        hflags_nxt[1] = 1'b1;
      end
    end else if (pos_r < 17'd12) begin
      idu_nxt = {idu_r[23:0], b};
    end else if (pos_r < HDR_BYTES) begin
      idl_nxt = {idl_r[55:0], b};
    end else if (pos_r < limit && !stop_r && !xor_found_r) begin
      if (!in_value_r) begin
        ahdr_nxt = hdr_new;
        if ({1'b0, pos_r} + 18'd1 == aend_r) begin
          if ({1'b0, aend_r} + {3'b0, alen} > {2'b0, limit}) begin
            stop_nxt = 1'b1;
          end else if (alen == 16'd0) begin
            aend_nxt = aend_r + 18'd4;
          end else begin
            aend_nxt     = aend_r + {1'b0, pad4(alen)};
            pend_nxt     = '0;
            in_value_nxt = 1'b1;
            fam_nxt      = 1'b0;
            voff_nxt     = '0;
          end
        end
      end else begin
        if (voff_r == 16'd1 && b == FAMILY_IPV4) begin
          fam_nxt = 1'b1;
        end
        if (voff_r >= 16'd2 && voff_r <= 16'd7) begin
          pend_nxt = {pend_r[39:0], b};
        end
        if (voff_inc == {1'b0, ahdr_r[15:0]} && ahdr_r[15:0] >= MIN_ADDR_LEN && fam_r) begin
          if (ahdr_r[31:16] == ATTR_XOR_MAPPED) begin
            xor_ep_nxt    = pend_nxt ^ XOR_MASK;
            xor_found_nxt = 1'b1;
          end else if (ahdr_r[31:16] == ATTR_MAPPED) begin
            plain_ep_nxt    = pend_nxt;
            plain_found_nxt = 1'b1;
          end
        end
        if (voff_inc == vpad) begin
          in_value_nxt = 1'b0;
          ahdr_nxt     = '0;
          aend_nxt     = {1'b0, pos_r} + 18'd5;
        end
        voff_nxt = voff_r + 16'd1;
      end
    end
  end

  always_comb begin
    result                = '0;
    result.status         = ST_NOT_STUN;
    result.message_kind   = KIND_OTHER;
    stun = (pos_nxt >= HDR_BYTES) && (hflags_nxt == 2'b00);
    if (stun) begin
      result.id_high = idu_nxt;
      result.id_low  = idl_nxt;
      if (mtype_nxt == MSG_BINDING_REQ) begin
        result.message_kind = KIND_BIND_REQ;
      end else if (mtype_nxt == MSG_BINDING_OK) begin
        result.message_kind = KIND_BIND_OK;
      end
      if (mtype_nxt != MSG_BINDING_OK) begin
        result.status = ST_NOT_SUCCESS;
      end else if (idu_nxt != exp_id_high || idl_nxt != exp_id_low) begin
        result.status = ST_ID_MISMATCH;
      end else if (xor_found_nxt) begin
        result.status         = ST_XOR_ADDR;
        result.mapped_port    = xor_ep_nxt[47:32];
        result.mapped_address = xor_ep_nxt[31:0];
      end else if (plain_found_nxt) begin
        result.status         = ST_PLAIN_ADDR;
        result.mapped_port    = plain_ep_nxt[47:32];
        result.mapped_address = plain_ep_nxt[31:0];
      end else begin
        result.status = ST_NONE_FOUND;
      end
    end
  end

  assign res.valid  = go && s1_last_r;
  assign res.result = result;

  always_ff @(posedge clk) begin
    if (!rst_n || (go && s1_last_r)) begin
      pos_r         <= '0;
      mtype_r       <= '0;
      dlen_r        <= '0;
      hflags_r      <= '0;
      idu_r         <= '0;
      idl_r         <= '0;
      ahdr_r        <= '0;
      aend_r        <= AEND_RESET;
      voff_r        <= '0;
      in_value_r    <= 1'b0;
      stop_r        <= 1'b0;
      plain_found_r <= 1'b0;
      xor_found_r   <= 1'b0;
      fam_r         <= 1'b0;
      pend_r        <= '0;
      plain_ep_r    <= '0;
      xor_ep_r      <= '0;
    end else if (go) begin
      pos_r         <= pos_nxt;
      mtype_r       <= mtype_nxt;
      dlen_r        <= dlen_nxt;
      hflags_r      <= hflags_nxt;
      idu_r         <= idu_nxt;
      idl_r         <= idl_nxt;
      ahdr_r        <= ahdr_nxt;
      aend_r        <= aend_nxt;
      voff_r        <= voff_nxt;
      in_value_r    <= in_value_nxt;
      stop_r        <= stop_nxt;
      plain_found_r <= plain_found_nxt;
      xor_found_r   <= xor_found_nxt;
      fam_r         <= fam_nxt;
      pend_r        <= pend_nxt;
      plain_ep_r    <= plain_ep_nxt;
      xor_ep_r      <= xor_ep_nxt;
    end
  end

endmodule

/* src/stunbrp_outreg.sv */
// ----------------------------------------------------------------------------
// STUN parser result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module stunbrp_outreg import stunbrp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  res_beat_t              res,
  output logic                   out_free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic    out_valid_r;
  result_t out_res_r;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_res_r <= res.result;
    end
  end

endmodule

/* src/stun_binding_response_parser.sv */
// A result beat is offered from the result register once the beat carrying the last byte has passed the input register.
// Throughput: one datagram byte per cycle while the byte engine is not stalled, including back-to-back datagrams.
// The byte engine stalls only when a last byte meets a result still waiting downstream.
// Reset clears the expected id to zero and returns the parser to the start of a datagram.
// ----------------------------------------------------------------------------
// STUN binding response parser
// Parses a datagram byte stream, checks the STUN header and transaction id,
// and reports the reflexive IPv4 address of a binding success response.
// ----------------------------------------------------------------------------
module stun_binding_response_parser import stunbrp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] status, [4:3] message_kind, [36:5] mapped_address,
  // [52:37] mapped_port, [84:53] id_high, [148:85] id_low
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [31:0] exp_id_high;
  logic [63:0] exp_id_low;
  logic        out_free;
  res_beat_t   res;

  stunbrp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .exp_id_high (exp_id_high),
    .exp_id_low  (exp_id_low)
  );

  stunbrp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .exp_id_high (exp_id_high),
    .exp_id_low  (exp_id_low),
    .out_free    (out_free),
    .res         (res)
  );

  stunbrp_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* src/stunbrp_checker.sv */
// ----------------------------------------------------------------------------
// STUN parser port checker
// Watches the result channel for a stable stalled beat and consistent fields.
// ----------------------------------------------------------------------------
`include "stun_binding_response_parser_macros.svh"

module stunbrp_checker import stunbrp_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  result_t r;
  logic    addr_status;

  assign r           = result_t'(out_tdata[RESULT_W-1:0]);
  assign addr_status = (r.status == ST_XOR_ADDR) || (r.status == ST_PLAIN_ADDR);

  `STUNBRP_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `STUNBRP_ASSERT_IMP(a_status_range, clk, rst_n, out_tvalid, r.status <= ST_NONE_FOUND)
  `STUNBRP_ASSERT_IMP(a_not_stun_clear, clk, rst_n, out_tvalid && r.status == ST_NOT_STUN, r.message_kind == KIND_OTHER && r.id_high == 32'd0 && r.id_low == 64'd0)
  `STUNBRP_ASSERT_IMP(a_addr_kind, clk, rst_n, out_tvalid && addr_status, r.message_kind == KIND_BIND_OK)
  `STUNBRP_ASSERT_IMP(a_no_addr_zero, clk, rst_n, out_tvalid && !addr_status, r.mapped_address == 32'd0 && r.mapped_port == 16'd0)

endmodule

bind stun_binding_response_parser stunbrp_checker u_stunbrp_checker (.*);
